// ===== src/rsp_pkg.sv =====
// Shared types, character codes and hex helper for the response framer.
// No dependencies; used by every module under src.
package rsp_pkg;

    localparam logic [7:0] CHAR_ACK   = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_START = 8'h24;  // '$'
    localparam logic [7:0] CHAR_HASH  = 8'h23;  // '#'
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // One buffered request from the input side.
    typedef struct packed {
        logic       cmd_end;   // 1 = end of packet
        logic [7:0] data;      // payload byte
    } item_t;

    // Character being emitted for the held request.
    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_ACK   = 8'b0000_0010,
        PH_START = 8'b0000_0100,
        PH_HI    = 8'b0000_1000,
        PH_LO    = 8'b0001_0000,
        PH_HASH  = 8'b0010_0000,
        PH_SUMHI = 8'b0100_0000,
        PH_SUMLO = 8'b1000_0000
    } phase_t;

    // Uppercase ASCII hex digit.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [3:0] n;
        n = nib & NIBBLE_MASK;
        if (n < 4'd10)
            hex_char = 8'h30 + {4'd0, n};
        else
            hex_char = 8'h37 + {4'd0, n};
    endfunction

endpackage

// ===== src/rsp_in_reg.sv =====
// Input holding register for requests of the response framer.
// Depends on rsp_pkg (item_t).
module rsp_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,    // [7:0] payload_byte
    input  logic          s_axis_tlast,    // cmd: 1 = end of packet
    output logic          item_valid,
    output rsp_pkg::item_t item,
    input  logic          item_pop
);

    logic           valid_reg;
    logic           valid_next;
    rsp_pkg::item_t item_reg;
    logic           take;

    // Refill in the same cycle the held request finishes.
    assign s_axis_tready = !valid_reg || item_pop;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (item_pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.cmd_end <= s_axis_tlast;
            item_reg.data    <= s_axis_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/rsp_char_seq.sv =====
// Character sequencer: expands the held request into framed characters,
// keeps the packet state and checksum, drives the output register.
// Depends on rsp_pkg.
module rsp_char_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  rsp_pkg::item_t item,
    output logic           item_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [7:0]     m_axis_tdata,   // [7:0] out_char
    output logic           m_axis_tlast    // frame_end
);

    rsp_pkg::phase_t phase_reg, phase_next;
    rsp_pkg::phase_t cur_phase, first_phase, after_phase;
    logic            in_packet_reg, in_packet_next;
    logic [7:0]      sum_reg, sum_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_char_reg;
    logic            out_end_reg;
    logic [7:0]      ch;
    logic            ch_end;
    logic            load;

    assign load = item_valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        if (!in_packet_reg)
            first_phase = rsp_pkg::PH_ACK;
        else if (item.cmd_end)
            first_phase = rsp_pkg::PH_HASH;
        else
            first_phase = rsp_pkg::PH_HI;

        cur_phase = (phase_reg == rsp_pkg::PH_IDLE) ? first_phase : phase_reg;

        ch             = rsp_pkg::CHAR_ACK;
        ch_end         = 1'b0;
        after_phase    = rsp_pkg::PH_IDLE;
        sum_next       = sum_reg;
        in_packet_next = in_packet_reg;

        case (cur_phase)
            rsp_pkg::PH_ACK:
            begin
                ch          = rsp_pkg::CHAR_ACK;
                after_phase = rsp_pkg::PH_START;
            end
            rsp_pkg::PH_START:
            begin
                ch             = rsp_pkg::CHAR_START;
                in_packet_next = 1'b1;
                after_phase    = item.cmd_end ? rsp_pkg::PH_HASH : rsp_pkg::PH_HI;
            end
            rsp_pkg::PH_HI:
            begin
                ch          = rsp_pkg::hex_char(item.data[7:4]);
                sum_next    = sum_reg + ch;
                after_phase = rsp_pkg::PH_LO;
            end
            rsp_pkg::PH_LO:
            begin
                ch          = rsp_pkg::hex_char(item.data[3:0]);
                sum_next    = sum_reg + ch;
                after_phase = rsp_pkg::PH_IDLE;
            end
            rsp_pkg::PH_HASH:
            begin
                ch          = rsp_pkg::CHAR_HASH;
                after_phase = rsp_pkg::PH_SUMHI;
            end
            rsp_pkg::PH_SUMHI:
            begin
                ch          = rsp_pkg::hex_char(sum_reg[7:4]);
                after_phase = rsp_pkg::PH_SUMLO;
            end
            rsp_pkg::PH_SUMLO:
            begin
                ch             = rsp_pkg::hex_char(sum_reg[3:0]);
                ch_end         = 1'b1;
                sum_next       = 8'd0;
                in_packet_next = 1'b0;
                after_phase    = rsp_pkg::PH_IDLE;
            end
            default:
            begin
                ch          = rsp_pkg::CHAR_ACK;
                after_phase = rsp_pkg::PH_IDLE;
            end
        endcase

        phase_next = load ? after_phase : phase_reg;
        item_pop   = load && (after_phase == rsp_pkg::PH_IDLE);

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rsp_pkg::PH_IDLE;
            in_packet_reg <= 1'b0;
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                in_packet_reg <= in_packet_next;
                sum_reg       <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= ch;
            out_end_reg  <= ch_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_end_reg;

endmodule

// ===== src/rsp_response_framer.sv =====
// Top level of the remote-protocol response framer.
// Depends on rsp_pkg, rsp_in_reg and rsp_char_seq.
//
// Input stream (s_axis_*): one request per payload byte; tdata is the
// byte, tlast high marks the end-of-packet request (tdata ignored then).
// Output stream (m_axis_*): one ASCII character per transfer; tlast is
// high on the last checksum digit of a packet.
// A packet's first request is preceded by "+$"; each byte becomes two
// uppercase hex digits; the end request adds '#' and the two-digit
// modulo-256 sum of the payload characters. An end request with no
// payload before it yields "+$#00".
// A request is held in the input register, and its characters go out
// through the output register, one per cycle while m_axis_tready is high.
// A payload byte yields two characters (four when it opens a packet) and
// an end request three (five for an empty packet).
// s_axis_tready rises again in the cycle the held request's last
// character is loaded, so requests flow without gaps.
// When m_axis_tready is low the output register holds its character and
// the sequencer and input register stall behind it; nothing is dropped.
// Reset clears the open-packet flag, the checksum and both valid flags.
module rsp_response_framer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] payload_byte
    input  logic       s_axis_tlast,   // cmd: 1 = end of packet
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast    // frame_end
);

    logic           item_valid;
    logic           item_pop;
    rsp_pkg::item_t item;

    rsp_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    rsp_char_seq u_char_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== bench/rsp_frame_checker.sv =====
`timescale 1ns / 100ps
// Checker for the response framer: watches both stream ports, predicts the framed
// characters from each accepted request and compares them in order. Needs no package.
module rsp_frame_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    output int         fail_count,
    output int         chars_owed
);

    localparam logic [7:0] ASCII_ACK   = "+";
    localparam logic [7:0] ASCII_START = "$";
    localparam logic [7:0] ASCII_HASH  = "#";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } framed_char_t;

    framed_char_t owed_q[$];
    logic         pkt_open = 1'b0;
    logic [7:0]   char_sum = 8'h00;

    initial begin
        fail_count = 0;
        chars_owed = 0;
    end

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v > 4'd9)
            return 8'h41 + {4'd0, v - 4'd10};
        return 8'h30 + {4'd0, v};
    endfunction

    // Predict the characters one request produces and update packet state.
    task automatic frame_request(input logic is_end, input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = hex_digit(b[7:4]);
        lo = hex_digit(b[3:0]);
        if (!pkt_open) begin
            owed_q.push_back(framed_char_t'{ch: ASCII_ACK, last: 1'b0});
            owed_q.push_back(framed_char_t'{ch: ASCII_START, last: 1'b0});
            pkt_open = 1'b1;
        end
        if (!is_end) begin
            owed_q.push_back(framed_char_t'{ch: hi, last: 1'b0});
            owed_q.push_back(framed_char_t'{ch: lo, last: 1'b0});
            char_sum = char_sum + hi + lo;
        end
        else begin
            owed_q.push_back(framed_char_t'{ch: ASCII_HASH, last: 1'b0});
            owed_q.push_back(framed_char_t'{ch: hex_digit(char_sum[7:4]), last: 1'b0});
            owed_q.push_back(framed_char_t'{ch: hex_digit(char_sum[3:0]), last: 1'b1});
            pkt_open = 1'b0;
            char_sum = 8'h00;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        framed_char_t want;
        if (!rst_n) begin
            owed_q.delete();
            pkt_open = 1'b0;
            char_sum = 8'h00;
            chars_owed = 0;
        end
        else begin
            // output side first: a request's characters cannot leave at its own edge
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_q.size() == 0) begin
                    $display("%0t: unexpected char %h last %b", $time, m_axis_tdata,
                             m_axis_tlast);
                    fail_count++;
                end
                else begin
                    want = owed_q.pop_front();
                    if (m_axis_tdata !== want.ch) begin
                        $display("%0t: out_char expected %h got %h", $time, want.ch,
                                 m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $display("%0t: frame_end expected %b got %b", $time, want.last,
                                 m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                frame_request(s_axis_tlast, s_axis_tdata);
            chars_owed = owed_q.size();
        end
    end

endmodule

// ===== bench/rsp_response_framer_tb.sv =====
`timescale 1ns / 100ps
// Top of the response framer bench: clock, reset, request stimulus and receiver
// back-pressure. Depends on rsp_response_framer and rsp_frame_checker.
module rsp_response_framer_tb;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam int PHASE_ITEMS  = 143;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 200000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    int fail_count;
    int chars_owed;
    int send_idle_pct = 11;
    int recv_idle_pct = 67;
    int rx_cycle = 0;
    int hold_left = 0;
    int cycle_count = 0;

    rsp_response_framer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    rsp_frame_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .chars_owed    (chars_owed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial
    begin
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle == HOLD_AT)
                hold_left = HOLD_LEN;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one request and return at the edge where it is taken.
    task automatic send_request(input logic is_end, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tlast  <= is_end;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Mostly short packets, some long ones, some empty ones.
    task automatic random_packets(input int n_items);
        int sent;
        int roll;
        int len;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                len = 0;
            else if (roll < 15)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(1, 8);
            repeat (len)
                send_request(CMD_BYTE, 8'($urandom_range(0, 255)));
            // payload on the end request is don't-care; toggle it anyway
            send_request(CMD_END, 8'($urandom_range(0, 255)));
            sent += len + 1;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty packets back to back
        send_request(CMD_END, 8'h00);
        send_request(CMD_END, 8'hFF);
        // digit boundaries 9/A in both nibbles, byte extremes
        send_request(CMD_BYTE, 8'h00);
        send_request(CMD_BYTE, 8'hFF);
        send_request(CMD_BYTE, 8'h09);
        send_request(CMD_BYTE, 8'h0A);
        send_request(CMD_BYTE, 8'h90);
        send_request(CMD_BYTE, 8'hA0);
        send_request(CMD_BYTE, 8'h5A);
        send_request(CMD_END, 8'hFF);
        // checksum wraps past 8 bits
        send_request(CMD_BYTE, 8'hFF);
        send_request(CMD_BYTE, 8'hFF);
        send_request(CMD_BYTE, 8'hFF);
        send_request(CMD_END, 8'h00);
        // single byte packet
        send_request(CMD_BYTE, 8'h3C);
        send_request(CMD_END, 8'h00);

        random_packets(PHASE_ITEMS - 16);
        send_idle_pct = 67;
        recv_idle_pct = 11;
        random_packets(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_packets(PHASE_ITEMS);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (chars_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && chars_owed == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== rsp_response_framer.f =====
src/rsp_pkg.sv
src/rsp_in_reg.sv
src/rsp_char_seq.sv
src/rsp_response_framer.sv
bench/rsp_frame_checker.sv
bench/rsp_response_framer_tb.sv
